@@ sv/rc_packet_crc_unpack_failsafe_core_macros.svh @@
// ---------------------------------------------------------------------------
// rc_packet_crc_unpack_failsafe_core_macros.svh
// Assertion macros for the receiver modules; rcpk_back is the one that uses them.
// ---------------------------------------------------------------------------
`ifndef RC_PACKET_CRC_UNPACK_FAILSAFE_CORE_MACROS_SVH
`define RC_PACKET_CRC_UNPACK_FAILSAFE_CORE_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define RCPK_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rcpk assertion failed");
// next-cycle implication
`define RCPK_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rcpk assertion failed");
`else
`define RCPK_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RCPK_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ sv/rcpk_pkg.sv @@
// ---------------------------------------------------------------------------
// rcpk_pkg
// Types, constants and the CRC-8 step for the RC packet receiver.
// ---------------------------------------------------------------------------
package rcpk_pkg;

  // CRC-8, MSB first, init 0, no reflection, no final xor
  localparam logic [7:0]  CRC_POLY     = 8'hD5;

  // channel values
  localparam logic [10:0] CH_MIN       = 11'd172;
  localparam logic [10:0] CH_MAX       = 11'd1811;
  localparam logic [10:0] CH_MID       = 11'd992;
  localparam logic [10:0] STICK_SPAN   = 11'd1639;  // CH_MAX - CH_MIN
  localparam logic [9:0]  STICK_MAX    = 10'd1023;

  // register reset values
  localparam logic [15:0] TIMEOUT_RST  = 16'd1000;
  localparam logic [7:0]  TYPE_RST     = 8'h16;

  localparam logic [15:0] ELAPSED_MAX  = 16'hFFFF;
  localparam logic [3:0]  BYTE_CNT_MAX = 4'd15;
  localparam int          PAYLOAD_DEPTH = 7;

  // channel layout of one run
  localparam logic [3:0]  FIRST_AUX_CH = 4'd4;
  localparam logic [3:0]  FIRST_MID_CH = 4'd12;
  localparam logic [3:0]  LAST_CH      = 4'd15;

  typedef enum logic {
    ACT_BYTE = 1'b0,
    ACT_TICK = 1'b1
  } action_e;

  typedef enum logic {
    REG_LINK_TIMEOUT  = 1'b0,
    REG_EXPECTED_TYPE = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
    logic       end_of_packet;
  } item_t;

  typedef struct packed {
    logic [3:0]  channel_index;
    logic [10:0] channel_value;
    logic        is_failsafe;
    logic        link_up;
    logic [31:0] good_packets;
    logic [31:0] crc_errors;
    logic        last;
  } result_t;

  // one run of sixteen channels, handed from front to back
  typedef struct packed {
    logic            failsafe;
    logic            link_up;
    logic [31:0]     good_packets;
    logic [31:0]     crc_errors;
    logic [5:0][7:0] payload;  // packet bytes 1..6
  } cmd_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

@@ sv/rcpk_front.sv @@
// ---------------------------------------------------------------------------
// rcpk_front
// Accepts bytes and ticks, runs the CRC, classifies packets, ages the link
// and queues a channel run for every good packet or link loss.
// ---------------------------------------------------------------------------
module rcpk_front #(
  parameter int unsigned PACKET_BYTES = 14
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [0:0]            cfg_idx_i,
  input  logic [15:0]           cfg_wdata_i,
  input  logic                  push_i,
  input  rcpk_pkg::item_t       item_i,
  input  logic                  cmd_full_i,
  output logic                  cmd_push_o,
  output rcpk_pkg::cmd_t        cmd_o
);

  localparam logic [3:0] LAST_POS = 4'(PACKET_BYTES - 1);

  logic [15:0] timeout_q;
  logic [7:0]  type_q;
  logic [3:0]  byte_cnt_q;
  logic [7:0]  crc_q;
  logic [15:0] elapsed_q;
  logic [31:0] good_cnt_q;
  logic [31:0] err_cnt_q;
  logic [7:0]  payload_q [rcpk_pkg::PAYLOAD_DEPTH];

  logic accept, is_byte, is_tick, pkt_end, at_check, crc_ok, bad_crc, good, fire;

  // packet classification
  always_comb begin
    accept   = push_i && !cmd_full_i;
    is_byte  = accept && (item_i.action == rcpk_pkg::ACT_BYTE);
    is_tick  = accept && (item_i.action == rcpk_pkg::ACT_TICK);
    pkt_end  = is_byte && item_i.end_of_packet;
    at_check = (byte_cnt_q == LAST_POS);
    crc_ok   = (crc_q == item_i.data_byte);
    bad_crc  = pkt_end && at_check && !crc_ok;
    good     = pkt_end && at_check && crc_ok && (payload_q[0] == type_q);
    // age passes the timeout exactly when it leaves the timeout value
    fire     = is_tick && (elapsed_q == timeout_q) && (elapsed_q != rcpk_pkg::ELAPSED_MAX);
  end

  // run request; the link is up after a good packet and down after a loss
  always_comb begin
    cmd_push_o         = good || fire;
    cmd_o.failsafe     = fire;
    cmd_o.link_up      = good;
    cmd_o.good_packets = good ? (good_cnt_q + 32'd1) : good_cnt_q;
    cmd_o.crc_errors   = err_cnt_q;
    for (int i = 0; i < 6; i++) begin
      cmd_o.payload[i] = payload_q[i + 1];
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= rcpk_pkg::TIMEOUT_RST;
      type_q    <= rcpk_pkg::TYPE_RST;
    end else if (cfg_we_i) begin
      unique case (rcpk_pkg::reg_idx_e'(cfg_idx_i))
        rcpk_pkg::REG_LINK_TIMEOUT:  timeout_q <= cfg_wdata_i;
        rcpk_pkg::REG_EXPECTED_TYPE: type_q    <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // packet state, link age and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q <= '0;
      crc_q      <= '0;
      elapsed_q  <= '0;
      good_cnt_q <= '0;
      err_cnt_q  <= '0;
    end else begin
      if (is_byte) begin
        if (item_i.end_of_packet) begin
          byte_cnt_q <= '0;
          crc_q      <= '0;
        end else begin
          if (byte_cnt_q != rcpk_pkg::BYTE_CNT_MAX) byte_cnt_q <= byte_cnt_q + 4'd1;
          if (byte_cnt_q < LAST_POS) crc_q <= rcpk_pkg::crc8_byte(crc_q, item_i.data_byte);
        end
      end
      if (is_tick && (elapsed_q != rcpk_pkg::ELAPSED_MAX)) elapsed_q <= elapsed_q + 16'd1;
      if (good) begin
        elapsed_q  <= '0;
        good_cnt_q <= good_cnt_q + 32'd1;
      end
      if (bad_crc) err_cnt_q <= err_cnt_q + 32'd1;
    end
  end

  // payload capture, bytes 0..6
  always_ff @(posedge clk_i) begin
    if (is_byte && (byte_cnt_q < 4'(rcpk_pkg::PAYLOAD_DEPTH))) begin
      payload_q[byte_cnt_q[2:0]] <= item_i.data_byte;
    end
  end

endmodule

@@ sv/rcpk_cmd_fifo.sv @@
// ---------------------------------------------------------------------------
// rcpk_cmd_fifo
// Two-entry run queue between the front and the back.
// ---------------------------------------------------------------------------
module rcpk_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rcpk_pkg::cmd_t data_i,
  input  logic           pop_i,
  output logic           valid_o,
  output logic           full_o,
  output rcpk_pkg::cmd_t data_o
);

  logic [1:0]     cnt_q;
  rcpk_pkg::cmd_t head_q, spare_q;
  logic           head_from_in, head_from_spare, load_spare;

  always_comb begin
    valid_o         = (cnt_q != 2'd0);
    full_o          = (cnt_q == 2'd2);
    data_o          = head_q;
    head_from_in    = (push_i && (cnt_q == 2'd0)) || (push_i && pop_i && (cnt_q == 2'd1));
    head_from_spare = pop_i && (cnt_q == 2'd2);
    load_spare      = push_i && !pop_i && (cnt_q == 2'd1);
  end

  // fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      unique case (cnt_q)
        2'd0: if (push_i) cnt_q <= 2'd1;
        2'd1: begin
          if (push_i && !pop_i) cnt_q <= 2'd2;
          else if (!push_i && pop_i) cnt_q <= 2'd0;
        end
        2'd2: if (pop_i) cnt_q <= 2'd1;
        default: cnt_q <= '0;
      endcase
    end
  end

  // entries
  always_ff @(posedge clk_i) begin
    if (head_from_in) head_q <= data_i;
    else if (head_from_spare) head_q <= spare_q;
    if (load_spare) spare_q <= data_i;
  end

endmodule

@@ sv/rcpk_back.sv @@
// ---------------------------------------------------------------------------
// rcpk_back
// Walks a queued run over sixteen channels: stage 1 selects and scales,
// stage 2 divides the stick product by 1023 and holds the output word.
// ---------------------------------------------------------------------------
`include "rc_packet_crc_unpack_failsafe_core_macros.svh"

module rcpk_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  rcpk_pkg::cmd_t    cmd_i,
  output logic              cmd_pop_o,
  input  logic              pop_i,
  output logic              empty_o,
  output rcpk_pkg::result_t result_o
);

  typedef struct packed {
    logic [3:0]  ch;
    logic        failsafe;
    logic        link_up;
    logic [31:0] good;
    logic [31:0] err;
    logic        is_stick;
    logic [20:0] num;  // stick product or plain channel value
  } s1_t;

  logic [3:0]        ch_q;
  logic              v1_q, v2_q;
  s1_t               s1_q, s1_d;
  rcpk_pkg::result_t out_q, out_d;
  logic              ready1, ready2, issue;

  logic [9:0]  stick;
  logic [10:0] const_val;
  logic [7:0]  aux;
  logic [21:0] sum, q0x, rem;
  logic [11:0] q0, q;

  // flow control
  always_comb begin
    ready2    = !v2_q || pop_i;
    ready1    = !v1_q || ready2;
    issue     = cmd_valid_i && ready1;
    cmd_pop_o = issue && (ch_q == rcpk_pkg::LAST_CH);
    empty_o   = !v2_q;
    result_o  = out_q;
  end

  // stage 1: channel select and stick scaling
  always_comb begin
    unique case (ch_q[1:0])
      2'd0: stick = {cmd_i.payload[1][1:0], cmd_i.payload[0]};
      2'd1: stick = {cmd_i.payload[2][3:0], cmd_i.payload[1][7:2]};
      2'd2: stick = {cmd_i.payload[3][5:0], cmd_i.payload[2][7:4]};
      default: stick = {cmd_i.payload[4], cmd_i.payload[3][7:6]};
    endcase
    aux         = cmd_i.payload[5];
    s1_d.ch       = ch_q;
    s1_d.failsafe = cmd_i.failsafe;
    s1_d.link_up  = cmd_i.link_up;
    s1_d.good     = cmd_i.good_packets;
    s1_d.err      = cmd_i.crc_errors;
    s1_d.is_stick = 1'b0;
    priority if (cmd_i.failsafe) begin
      const_val = (ch_q == 4'd0 || ch_q == 4'd1 || ch_q == 4'd3) ? rcpk_pkg::CH_MID
                                                                 : rcpk_pkg::CH_MIN;
    end else if (ch_q < rcpk_pkg::FIRST_AUX_CH) begin
      const_val     = rcpk_pkg::CH_MIN;
      s1_d.is_stick = 1'b1;
    end else if (ch_q < rcpk_pkg::FIRST_MID_CH) begin
      const_val = aux[ch_q[2:0] - 3'd4] ? rcpk_pkg::CH_MAX : rcpk_pkg::CH_MIN;
    end else begin
      const_val = rcpk_pkg::CH_MID;
    end
    s1_d.num = s1_d.is_stick ? (21'(stick) * 21'(rcpk_pkg::STICK_SPAN)) : 21'(const_val);
  end

  // stage 2: divide by 1023 (estimate then one correction), offset
  always_comb begin
    sum = 22'(s1_q.num) + 22'(s1_q.num >> 10);
    q0  = sum[21:10];
    q0x = {q0, 10'b0} - 22'(q0);
    rem = 22'(s1_q.num) - q0x;
    q   = (rem >= 22'(rcpk_pkg::STICK_MAX)) ? (q0 + 12'd1) : q0;
    out_d.channel_index = s1_q.ch;
    out_d.channel_value = s1_q.is_stick ? (11'(q) + rcpk_pkg::CH_MIN) : s1_q.num[10:0];
    out_d.is_failsafe   = s1_q.failsafe;
    out_d.link_up       = s1_q.link_up;
    out_d.good_packets  = s1_q.good;
    out_d.crc_errors    = s1_q.err;
    out_d.last          = (s1_q.ch == rcpk_pkg::LAST_CH);
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q <= '0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (issue) ch_q <= ch_q + 4'd1;
      if (ready1) v1_q <= issue;
      if (ready2) v2_q <= v1_q;
    end
  end

  // stage data
  always_ff @(posedge clk_i) begin
    if (ready1) s1_q <= s1_d;
    if (ready2) out_q <= out_d;
  end

  `RCPK_ASSERT_IMP(a_stick_ch, clk_i, rst_ni, v1_q && s1_q.is_stick, s1_q.ch < rcpk_pkg::FIRST_AUX_CH)
  `RCPK_ASSERT_IMP(a_value_range, clk_i, rst_ni, v2_q, (out_q.channel_value >= rcpk_pkg::CH_MIN) && (out_q.channel_value <= rcpk_pkg::CH_MAX))
  `RCPK_ASSERT_IMP(a_failsafe_link, clk_i, rst_ni, v2_q && out_q.is_failsafe, !out_q.link_up)
  `RCPK_ASSERT_NXT(a_run_wrap, clk_i, rst_ni, cmd_pop_o, ch_q == 4'd0)

endmodule

@@ sv/rc_packet_crc_unpack_failsafe_core.sv @@
// Throughput: one byte or tick accepted per cycle while full is low; one result word
// leaves per cycle while pop is held. A run enters the run queue at the accepting edge of
// the end byte or tick, then the stage-1 and output registers; its sixteen words follow back to back.
// full rises while two runs wait in the run queue ahead of the channel sequencer.
// Reset (rst_ni, async, low) clears counters, link age and queues and loads the
// register defaults; captured packet bytes are not reset.
// ---------------------------------------------------------------------------
// rc_packet_crc_unpack_failsafe_core
// RC channel packet receiver: CRC-8 check, stick/aux unpacking, link failsafe.
// ---------------------------------------------------------------------------
module rc_packet_crc_unpack_failsafe_core #(
  parameter int unsigned PACKET_BYTES = 14
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_idx_i,
  input  logic [15:0]       cfg_wdata_i,
  input  logic              push,
  output logic              full,
  input  rcpk_pkg::item_t   in_item_i,
  output logic              empty,
  input  logic              pop,
  output rcpk_pkg::result_t result_o
);

  logic           cmd_push, cmd_full, cmd_valid, cmd_pop;
  rcpk_pkg::cmd_t cmd_in, cmd_head;

  assign full = cmd_full;

  rcpk_front #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push_i     (push),
    .item_i     (in_item_i),
    .cmd_full_i (cmd_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  rcpk_cmd_fifo u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (cmd_in),
    .pop_i  (cmd_pop),
    .valid_o(cmd_valid),
    .full_o (cmd_full),
    .data_o (cmd_head)
  );

  rcpk_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd_head),
    .cmd_pop_o  (cmd_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .result_o   (result_o)
  );

endmodule

@@ tb/rc_link_scoreboard_pkg.sv @@
// ---------------------------------------------------------------------------
// rc_link_scoreboard_pkg
// Channel predictor and scoreboard for the RC packet receiver testbench.
// ---------------------------------------------------------------------------
package rc_link_scoreboard_pkg;
  import rcpk_pkg::*;

  localparam int PKT_LEN = 14;

  class rc_link_scoreboard;
    // register copies
    bit [15:0] timeout_ms;
    bit [7:0]  want_type;
    // packet and link state
    bit [3:0]  nbytes;
    bit [7:0]  crc_acc;
    bit        crc_hit;
    bit [7:0]  held[PAYLOAD_DEPTH];
    bit [15:0] age_ms;
    bit        link;
    bit [31:0] good_cnt;
    bit [31:0] err_cnt;
    // channel words still owed by the block
    result_t   chan_q[$];
    int        words_in;
    int        words_out;
    int        packet_runs;
    int        failsafe_runs;
    int        faults;

    function new();
      timeout_ms = TIMEOUT_RST;
      want_type  = TYPE_RST;
    endfunction

    // bit-serial CRC-8, MSB first
    static function bit [7:0] crc8_step(bit [7:0] acc, bit [7:0] b);
      bit fb;
      for (int i = 7; i >= 0; i--) begin
        fb  = acc[7] ^ b[i];
        acc = {acc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
      end
      return acc;
    endfunction

    static function bit [10:0] stick_to_ch(bit [9:0] v);
      int unsigned t;
      t = 32'(v) * 32'(STICK_SPAN) / 32'(STICK_MAX) + 32'(CH_MIN);
      return t[10:0];
    endfunction

    function void reg_write(reg_idx_e idx, bit [15:0] val);
      case (idx)
        REG_LINK_TIMEOUT:  timeout_ms = val;
        REG_EXPECTED_TYPE: want_type  = val[7:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return chan_q.size();
    endfunction

    function void post_run(bit [10:0] vals[16], bit fs);
      result_t w;
      for (int k = 0; k < 16; k++) begin
        w.channel_index = 4'(k);
        w.channel_value = vals[k];
        w.is_failsafe   = fs;
        w.link_up       = link;
        w.good_packets  = good_cnt;
        w.crc_errors    = err_cnt;
        w.last          = (4'(k) == LAST_CH);
        chan_q.push_back(w);
      end
    endfunction

    // advance the predictor by one accepted word
    function void note_word(item_t it);
      bit [3:0]  pos;
      bit        whole;
      bit        ok;
      bit [15:0] prev;
      bit [10:0] vals[16];
      bit [9:0]  stick[4];
      words_in++;
      if (it.action == ACT_TICK) begin
        prev = age_ms;
        if (age_ms != ELAPSED_MAX) age_ms++;
        // link loss fires only on the crossing tick
        if (prev <= timeout_ms && age_ms > timeout_ms) begin
          link = 1'b0;
          foreach (vals[k]) vals[k] = CH_MIN;
          vals[0] = CH_MID;
          vals[1] = CH_MID;
          vals[3] = CH_MID;
          post_run(vals, 1'b1);
          failsafe_runs++;
        end
        return;
      end

      pos = nbytes;
      if (pos < PAYLOAD_DEPTH) held[pos] = it.data_byte;
      if (pos < PKT_LEN - 1) crc_acc = crc8_step(crc_acc, it.data_byte);
      else if (pos == PKT_LEN - 1) crc_hit = (crc_acc == it.data_byte);
      if (nbytes != BYTE_CNT_MAX) nbytes++;
      if (!it.end_of_packet) return;

      whole   = (pos == PKT_LEN - 1);
      ok      = crc_hit;
      nbytes  = '0;
      crc_acc = '0;
      crc_hit = 1'b0;
      if (!whole) return;
      if (!ok) begin
        err_cnt++;
        return;
      end
      if (held[0] != want_type) return;

      // four 10-bit sticks packed LSB first from byte 1
      stick[0] = {held[2][1:0], held[1]};
      stick[1] = {held[3][3:0], held[2][7:2]};
      stick[2] = {held[4][5:0], held[3][7:4]};
      stick[3] = {held[5], held[4][7:6]};
      for (int k = 0; k < 4; k++) vals[k] = stick_to_ch(stick[k]);
      for (int k = 0; k < 8; k++) vals[FIRST_AUX_CH + k] = held[6][k] ? CH_MAX : CH_MIN;
      for (int k = FIRST_MID_CH; k < 16; k++) vals[k] = CH_MID;

      good_cnt++;
      age_ms = '0;
      link   = 1'b1;
      post_run(vals, 1'b0);
      packet_runs++;
    endfunction

    static function string show(result_t w);
      return $sformatf("ch %0d val %0d fs %0b up %0b good %0d crcerr %0d last %0b",
                       w.channel_index, w.channel_value, w.is_failsafe, w.link_up,
                       w.good_packets, w.crc_errors, w.last);
    endfunction

    // compare one popped word with the oldest expectation
    function void check_word(result_t got);
      result_t want;
      words_out++;
      if (chan_q.size() == 0) begin
        if (faults < 10) $display("ERROR: unexpected word: %s", show(got));
        faults++;
        return;
      end
      want = chan_q.pop_front();
      if (got.channel_index !== want.channel_index ||
          got.channel_value !== want.channel_value ||
          got.is_failsafe   !== want.is_failsafe   ||
          got.link_up       !== want.link_up       ||
          got.good_packets  !== want.good_packets  ||
          got.crc_errors    !== want.crc_errors    ||
          got.last          !== want.last) begin
        if (faults < 10) begin
          $display("ERROR: word mismatch at %0t", $realtime);
          $display("  expected: %s", show(want));
          $display("  actual:   %s", show(got));
        end
        faults++;
      end
    endfunction
  endclass

endpackage

@@ tb/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench
// Drives radio packet bytes and millisecond ticks into the RC packet receiver
// and checks every channel word against a cycle-free predictor: good, bad-CRC,
// wrong-type and wrong-length packets, link-loss failsafe, register extremes,
// random stalls on both sides and a long output hold-off that fills the block.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rcpk_pkg::*;
  import rc_link_scoreboard_pkg::*;

  localparam int HOLD_CYCLES = 300;

  typedef enum int {PKT_GOOD, PKT_BAD_CRC, PKT_WRONG_TYPE, PKT_WRONG_LEN} pkt_kind_e;
  typedef bit [7:0] byte_q_t[$];

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [0:0]  cfg_idx_i;
  logic [15:0] cfg_wdata_i;
  logic        push;
  logic        full;
  item_t       in_item;
  logic        empty;
  logic        pop;
  result_t     result;

  rc_link_scoreboard board;
  bit [7:0]          cur_type = TYPE_RST;
  bit                quiet;
  bit                hold_req;
  int                full_cycles;

  rc_packet_crc_unpack_failsafe_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .result_o   (result)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic item_t mk_word(action_e a, bit [7:0] b, bit e);
    item_t it;
    it.action        = a;
    it.data_byte     = b;
    it.end_of_packet = e;
    return it;
  endfunction

  // tick with random don't-care byte and end mark
  function automatic item_t tick_word();
    return mk_word(ACT_TICK, 8'($urandom), 1'($urandom));
  endfunction

  function automatic bit [7:0] crc_of(byte_q_t body);
    bit [7:0] acc;
    acc = '0;
    foreach (body[i]) acc = rc_link_scoreboard::crc8_step(acc, body[i]);
    return acc;
  endfunction

  // offer one word, optionally after an idle burst; returns at the accepting edge
  task automatic send_word(input item_t it);
    bit took;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    push    <= 1'b1;
    in_item <= it;
    took = 1'b0;
    while (!took) begin
      @(negedge clk_i);
      took = !full;
      if (full) full_cycles++;
      @(posedge clk_i);
    end
    board.note_word(it);
  endtask

  // packet bytes with a stray tick now and then
  task automatic send_frame(input byte_q_t body);
    foreach (body[i]) begin
      if ($urandom_range(0, 11) == 0) send_word(tick_word());
      send_word(mk_word(ACT_BYTE, body[i], i == body.size() - 1));
    end
  endtask

  task automatic send_packet(input pkt_kind_e kind);
    byte_q_t body;
    int      n;
    if (kind == PKT_WRONG_LEN) begin
      n = ($urandom_range(0, 1) != 0) ? $urandom_range(1, PKT_LEN - 1)
                                      : $urandom_range(PKT_LEN + 1, PKT_LEN + 6);
      repeat (n) body.push_back(8'($urandom));
    end else begin
      body.push_back(kind == PKT_WRONG_TYPE ? cur_type ^ 8'($urandom_range(1, 255))
                                            : cur_type);
      repeat (PKT_LEN - 2) body.push_back(8'($urandom));
      body.push_back(crc_of(body) ^ (kind == PKT_BAD_CRC ? 8'($urandom_range(1, 255))
                                                         : 8'h00));
    end
    send_frame(body);
  endtask

  // mostly good packets, the rest broken ones and tick bursts
  task automatic run_mix(input int n);
    int r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 55) send_packet(PKT_GOOD);
      else if (r < 65) send_packet(PKT_BAD_CRC);
      else if (r < 75) send_packet(PKT_WRONG_TYPE);
      else if (r < 85) send_packet(PKT_WRONG_LEN);
      else repeat ($urandom_range(1, 8)) send_word(tick_word());
    end
  endtask

  task automatic write_reg(input reg_idx_e idx, input bit [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    board.reg_write(idx, val);
    if (idx == REG_EXPECTED_TYPE) cur_type = val[7:0];
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // stop sending and let every owed word come out
  task automatic quiesce();
    push <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // result side: random stalls, long hold-off on request
  initial begin : drain_side
    int      stall;
    int      hold_left;
    bit      took;
    result_t got;
    stall     = 0;
    hold_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      took = pop && !empty;
      got  = result;
      @(posedge clk_i);
      if (took) board.check_word(got);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 5) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #10ms;
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    byte_q_t body;
    board       = new();
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    push        = 1'b0;
    in_item     = '0;
    pop         = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: failsafe with no link since reset, extreme sticks, lone end mark
    write_reg(REG_LINK_TIMEOUT, 16'd1);
    repeat (2) send_word(tick_word());
    body = '{cur_type, 8'hFF, 8'h03, 8'hF0, 8'h3F, 8'h00, 8'hA5};
    repeat (6) body.push_back(8'($urandom));
    body.push_back(crc_of(body));
    send_frame(body);
    send_word(mk_word(ACT_BYTE, 8'hFF, 1'b1));
    repeat (2) send_word(tick_word());
    quiesce();

    // short timeout, reset type
    write_reg(REG_LINK_TIMEOUT, 16'd5);
    run_mix(8);

    // hold the output while good packets keep coming so the block backs up
    hold_req = 1'b1;
    repeat (4) send_packet(PKT_GOOD);
    quiesce();

    // zero timeout, all-ones type (upper data bits must be ignored)
    write_reg(REG_LINK_TIMEOUT, 16'd0);
    write_reg(REG_EXPECTED_TYPE, 16'hFFFF);
    run_mix(8);
    quiesce();

    // max timeout never fires
    write_reg(REG_LINK_TIMEOUT, 16'hFFFF);
    write_reg(REG_EXPECTED_TYPE, 16'h0000);
    run_mix(5);
    quiet = 1'b1;
    repeat (8) send_word(tick_word());
    quiet = 1'b0;
    quiesce();

    // age already above a small timeout: no crossing until a good packet
    write_reg(REG_LINK_TIMEOUT, 16'd3);
    repeat (4) send_word(tick_word());
    run_mix(3);
    quiesce();

    // random settings, back-to-back traffic
    write_reg(REG_LINK_TIMEOUT, 16'($urandom_range(2, 12)));
    write_reg(REG_EXPECTED_TYPE, 16'($urandom_range(0, 255)));
    quiet = 1'b1;
    run_mix(8);
    quiesce();
    repeat (8) @(posedge clk_i);

    $display("Covered %0d input words and %0d channel words: %0d packet runs, %0d failsafe runs",
             board.words_in, board.words_out, board.packet_runs, board.failsafe_runs);
    $display("Predicted %0d CRC errors; input stalled by full for %0d cycles; %0d mismatches",
             board.err_cnt, full_cycles, board.faults);
    if (board.faults == 0 && board.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/rcpk_pkg.sv
sv/rcpk_front.sv
sv/rcpk_cmd_fifo.sv
sv/rcpk_back.sv
sv/rc_packet_crc_unpack_failsafe_core.sv
tb/rc_link_scoreboard_pkg.sv
tb/testbench.sv
